FILE: design/lps_pkg.sv
// ----------------------------------------------------------------------------
// LCA path-sum engine package
// Shared types, field widths and sequencer states.
// ----------------------------------------------------------------------------
package lps_pkg;

  localparam int MAX_NODES_DEF = 1024;
  localparam int LEVELS_DEF    = 10;
  localparam int FIELD_NODE_W  = 10;
  localparam int VAL_W         = 32;
  localparam int SUM_W         = 48;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic                           mode;
    logic [FIELD_NODE_W-1:0]        node;
    logic [FIELD_NODE_W-1:0]        parent_node;
    logic signed [VAL_W-1:0]        edge_weight;
    logic signed [VAL_W-1:0]        node_value;
    logic [FIELD_NODE_W-1:0]        other_node;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_NODE_W-1:0]        common_ancestor;
    logic signed [SUM_W-1:0]        node_total;
    logic signed [SUM_W-1:0]        edge_total;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LD_PAR,
    S_LD_RD,
    S_LD_WR,
    S_Q_DEP,
    S_Q_UP_RD,
    S_Q_UP_WR,
    S_Q_JMP_RD,
    S_Q_JMP_WR,
    S_Q_FIN_RD,
    S_Q_FIN_WR,
    S_Q_VAL_RD,
    S_Q_OUT
  } seq_state_t;

  function automatic logic [SUM_W-1:0] sext_val(input logic [VAL_W-1:0] x);
    sext_val = {{(SUM_W-VAL_W){x[VAL_W-1]}}, x};
  endfunction

endpackage

FILE: design/lps_ram.sv
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/lps_seq.sv
// ----------------------------------------------------------------------------
// LCA path-sum sequencer
// Runs loads and queries against the node and lifting-row memories.
// ----------------------------------------------------------------------------
module lps_seq #(
  parameter int MAX_NODES = 1024,
  parameter int LEVELS    = 10
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  lps_pkg::in_item_t                     in_data,
  output logic                                  res_valid,
  input  logic                                  res_ready,
  output lps_pkg::out_item_t                    res_data,
  output logic                                  row_we,
  output logic [$clog2(MAX_NODES)+$clog2(LEVELS)-1:0] row_waddr,
  output logic [$clog2(MAX_NODES)+2*lps_pkg::SUM_W-1:0] row_wdata,
  output logic [$clog2(MAX_NODES)+$clog2(LEVELS)-1:0] row_raddr_a,
  output logic [$clog2(MAX_NODES)+$clog2(LEVELS)-1:0] row_raddr_b,
  input  logic [$clog2(MAX_NODES)+2*lps_pkg::SUM_W-1:0] row_rdata_a,
  input  logic [$clog2(MAX_NODES)+2*lps_pkg::SUM_W-1:0] row_rdata_b,
  output logic                                  node_we,
  output logic [$clog2(MAX_NODES)-1:0]          node_waddr,
  output logic [LEVELS+lps_pkg::VAL_W-1:0]      node_wdata,
  output logic [$clog2(MAX_NODES)-1:0]          node_raddr_a,
  output logic [$clog2(MAX_NODES)-1:0]          node_raddr_b,
  input  logic [LEVELS+lps_pkg::VAL_W-1:0]      node_rdata_a,
  input  logic [LEVELS+lps_pkg::VAL_W-1:0]      node_rdata_b
);
  import lps_pkg::*;

  localparam int NW = $clog2(MAX_NODES);
  localparam int LW = $clog2(LEVELS);
  localparam logic [LW-1:0] LAST_LVL = LW'(LEVELS - 1);

  seq_state_t        state_r, state_nxt;
  logic [NW-1:0]     u_r, u_nxt, v_r, v_nxt;
  logic [SUM_W-1:0]  ns_r, ns_nxt, es_r, es_nxt;
  logic [LW-1:0]     k_r, k_nxt;
  logic [LEVELS-1:0] diff_r, diff_nxt;
  logic              zra_r, zrb_r, zna_r, znb_r;

  logic [NW-1:0]     ra_node_a, ra_node_b, up_u;
  logic [LW-1:0]     ra_lvl;
  logic [NW-1:0]     ra_anc, rb_anc;
  logic [SUM_W-1:0]  ra_ns, ra_es, rb_ns, rb_es;
  logic [LEVELS-1:0] dep_a, dep_b;
  logic [VAL_W-1:0]  val_a;
  logic              nd_ok, par_ok, oth_ok;
  logic [NW-1:0]     nd_idx, par_idx, oth_idx;

  // Entry zero of every store is never written; reads of it are forced to zero.
  assign ra_anc = zra_r ? '0 : row_rdata_a[NW+2*SUM_W-1 -: NW];
  assign ra_ns  = zra_r ? '0 : row_rdata_a[2*SUM_W-1 -: SUM_W];
  assign ra_es  = zra_r ? '0 : row_rdata_a[SUM_W-1:0];
  assign rb_anc = zrb_r ? '0 : row_rdata_b[NW+2*SUM_W-1 -: NW];
  assign rb_ns  = zrb_r ? '0 : row_rdata_b[2*SUM_W-1 -: SUM_W];
  assign rb_es  = zrb_r ? '0 : row_rdata_b[SUM_W-1:0];
  assign dep_a  = zna_r ? '0 : node_rdata_a[LEVELS+VAL_W-1 -: LEVELS];
  assign dep_b  = znb_r ? '0 : node_rdata_b[LEVELS+VAL_W-1 -: LEVELS];
  assign val_a  = zna_r ? '0 : node_rdata_a[VAL_W-1:0];

  assign nd_ok   = 32'(in_data.node) < MAX_NODES;
  assign par_ok  = 32'(in_data.parent_node) < MAX_NODES;
  assign oth_ok  = 32'(in_data.other_node) < MAX_NODES;
  assign nd_idx  = nd_ok ? NW'(in_data.node) : '0;
  assign par_idx = NW'(in_data.parent_node);
  assign oth_idx = oth_ok ? NW'(in_data.other_node) : '0;

  assign up_u = diff_r[k_r] ? ra_anc : u_r;

  assign row_raddr_a  = {ra_node_a, ra_lvl};
  assign row_raddr_b  = {ra_node_b, ra_lvl};
  assign in_stall     = (state_r != S_IDLE);

  assign res_data.common_ancestor = FIELD_NODE_W'(u_r);
  assign res_data.node_total      = ns_r + sext_val(val_a);
  assign res_data.edge_total      = es_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    u_r    <= u_nxt;
    v_r    <= v_nxt;
    ns_r   <= ns_nxt;
    es_r   <= es_nxt;
    k_r    <= k_nxt;
    diff_r <= diff_nxt;
    zra_r  <= (ra_node_a == '0);
    zrb_r  <= (ra_node_b == '0);
    zna_r  <= (node_raddr_a == '0);
    znb_r  <= (node_raddr_b == '0);
  end

  always_comb begin
    state_nxt    = state_r;
    u_nxt        = u_r;
    v_nxt        = v_r;
    ns_nxt       = ns_r;
    es_nxt       = es_r;
    k_nxt        = k_r;
    diff_nxt     = diff_r;
    row_we       = 1'b0;
    row_waddr    = {u_r, k_r};
    row_wdata    = {v_r, ns_r, es_r};
    ra_node_a    = u_r;
    ra_node_b    = v_r;
    ra_lvl       = k_r;
    node_we      = 1'b0;
    node_waddr   = u_r;
    node_wdata   = {dep_a, ns_r[VAL_W-1:0]};
    node_raddr_a = u_r;
    node_raddr_b = v_r;
    res_valid    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.mode == MODE_LOAD) begin
            if (in_data.node != '0 && nd_ok && par_ok) begin
              u_nxt        = nd_idx;
              v_nxt        = par_idx;
              ns_nxt       = sext_val(in_data.node_value);
              es_nxt       = sext_val(in_data.edge_weight);
              node_raddr_a = par_idx;
              state_nxt    = S_LD_PAR;
            end
          end else begin
            u_nxt        = nd_idx;
            v_nxt        = oth_idx;
            node_raddr_a = nd_idx;
            node_raddr_b = oth_idx;
            state_nxt    = S_Q_DEP;
          end
        end
      end
      S_LD_PAR: begin
        node_we    = 1'b1;
        node_wdata = {(v_r == '0) ? LEVELS'(0) : dep_a + LEVELS'(1), ns_r[VAL_W-1:0]};
        row_we     = 1'b1;
        row_waddr  = {u_r, LW'(0)};
        k_nxt      = LW'(1);
        state_nxt  = S_LD_RD;
      end
      S_LD_RD: begin
        ra_node_a = v_r;
        ra_lvl    = k_r - LW'(1);
        state_nxt = S_LD_WR;
      end
      S_LD_WR: begin
        row_we    = 1'b1;
        row_wdata = {ra_anc, ns_r + ra_ns, es_r + ra_es};
        v_nxt     = ra_anc;
        ns_nxt    = ns_r + ra_ns;
        es_nxt    = es_r + ra_es;
        if (k_r == LAST_LVL) begin
          state_nxt = S_IDLE;
        end else begin
          k_nxt     = k_r + LW'(1);
          state_nxt = S_LD_RD;
        end
      end
      S_Q_DEP: begin
        if (dep_a < dep_b) begin
          u_nxt    = v_r;
          v_nxt    = u_r;
          diff_nxt = dep_b - dep_a;
        end else begin
          diff_nxt = dep_a - dep_b;
        end
        ns_nxt    = '0;
        es_nxt    = '0;
        k_nxt     = '0;
        state_nxt = S_Q_UP_RD;
      end
      S_Q_UP_RD: begin
        state_nxt = S_Q_UP_WR;
      end
      S_Q_UP_WR: begin
        if (diff_r[k_r]) begin
          ns_nxt = ns_r + ra_ns;
          es_nxt = es_r + ra_es;
        end
        u_nxt = up_u;
        if (k_r == LAST_LVL) begin
          state_nxt = (up_u == v_r) ? S_Q_VAL_RD : S_Q_JMP_RD;
        end else begin
          k_nxt     = k_r + LW'(1);
          state_nxt = S_Q_UP_RD;
        end
      end
      S_Q_JMP_RD: begin
        state_nxt = S_Q_JMP_WR;
      end
      S_Q_JMP_WR: begin
        if (ra_anc != rb_anc) begin
          ns_nxt = ns_r + ra_ns + rb_ns;
          es_nxt = es_r + ra_es + rb_es;
          u_nxt  = ra_anc;
          v_nxt  = rb_anc;
        end
        if (k_r == '0) begin
          state_nxt = S_Q_FIN_RD;
        end else begin
          k_nxt     = k_r - LW'(1);
          state_nxt = S_Q_JMP_RD;
        end
      end
      S_Q_FIN_RD: begin
        state_nxt = S_Q_FIN_WR;
      end
      S_Q_FIN_WR: begin
        ns_nxt    = ns_r + ra_ns + rb_ns;
        es_nxt    = es_r + ra_es + rb_es;
        u_nxt     = ra_anc;
        state_nxt = S_Q_VAL_RD;
      end
      S_Q_VAL_RD: begin
        state_nxt = S_Q_OUT;
      end
      S_Q_OUT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/lca_path_sum_engine_top.sv
// ----------------------------------------------------------------------------
// LCA path-sum engine
// Binary-lifting tree store answering lowest-common-ancestor path-sum queries.
// ----------------------------------------------------------------------------
// Usage. Each beat on the input channel (in_valid, in_stall, in_data) is a
// load or a query. A load writes one node, whose parent must have been loaded
// before it; it gives no result beat. A query gives exactly one beat on the
// output channel (out_valid, out_stall, out_data): the lowest common ancestor
// and the node-value and edge-weight sums along the path between the two
// endpoints, with the ancestor's value counted once.
// Throughput is set by the single sequencer, which works on one item at a
// time and walks the lifting-row memory level by level, with a read state
// and a write state per level; a query whose endpoints meet after the depth
// equalising pass skips the jump pass. in_stall is high while an item is
// being worked on. Results sit in an output register, so a new item is
// taken while a result waits; a query only pauses at its final step if the
// previous result has still not been taken.
// Reset clears the control state only; node zero acts as the empty root
// sentinel and reads as zero, so the block is ready right after reset.
// ----------------------------------------------------------------------------
module lca_path_sum_engine_top #(
  parameter int MAX_NODES = lps_pkg::MAX_NODES_DEF,
  parameter int LEVELS    = lps_pkg::LEVELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lps_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lps_pkg::out_item_t out_data
);
  import lps_pkg::*;

  localparam int NW     = $clog2(MAX_NODES);
  localparam int LW     = $clog2(LEVELS);
  localparam int RA     = NW + LW;
  localparam int RW     = NW + 2*SUM_W;
  localparam int ND     = LEVELS + VAL_W;
  localparam int RDEPTH = MAX_NODES * (1 << LW);

  logic          res_valid, res_ready;
  out_item_t     res_data;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r;

  logic          row_we, node_we;
  logic [RA-1:0] row_waddr, row_raddr_a, row_raddr_b;
  logic [RW-1:0] row_wdata, row_rdata_a, row_rdata_b;
  logic [NW-1:0] node_waddr, node_raddr_a, node_raddr_b;
  logic [ND-1:0] node_wdata, node_rdata_a, node_rdata_b;

  lps_seq #(.MAX_NODES(MAX_NODES), .LEVELS(LEVELS)) u_seq (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .res_valid, .res_ready, .res_data,
    .row_we, .row_waddr, .row_wdata, .row_raddr_a, .row_raddr_b,
    .row_rdata_a, .row_rdata_b,
    .node_we, .node_waddr, .node_wdata, .node_raddr_a, .node_raddr_b,
    .node_rdata_a, .node_rdata_b
  );

  // The lifting rows and the node entries are each kept in two identical
  // copies, so that both query endpoints can be read in the same cycle.
  lps_ram #(.WIDTH(RW), .DEPTH(RDEPTH)) u_row_a (
    .clk, .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
    .raddr(row_raddr_a), .rdata(row_rdata_a)
  );
  lps_ram #(.WIDTH(RW), .DEPTH(RDEPTH)) u_row_b (
    .clk, .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
    .raddr(row_raddr_b), .rdata(row_rdata_b)
  );
  lps_ram #(.WIDTH(ND), .DEPTH(MAX_NODES)) u_node_a (
    .clk, .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .raddr(node_raddr_a), .rdata(node_rdata_a)
  );
  lps_ram #(.WIDTH(ND), .DEPTH(MAX_NODES)) u_node_b (
    .clk, .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .raddr(node_raddr_b), .rdata(node_rdata_b)
  );

  // Output register: a finished result moves in whenever the slot is empty
  // or its current beat is being taken.
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A result held back by a full output register must still be offered.
  a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while output register full");

  // The sentinel entry of node zero is never overwritten.
  a_row_zero: assert property (@(posedge clk) disable iff (!rst_n)
    row_we |-> row_waddr[RA-1 -: NW] != '0)
    else $error("lifting row of node zero written");

  a_node_zero: assert property (@(posedge clk) disable iff (!rst_n)
    node_we |-> node_waddr != '0)
    else $error("node entry zero written");

  // A result is only produced while the sequencer holds the input side.
  a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> in_stall)
    else $error("result offered while sequencer idle");

endmodule

FILE: bench/tb_lca_path_sum_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCA path-sum engine testbench
// Loads random forests and long chains into the engine and checks every query
// beat, field by field, against an in-bench binary-lifting predictor.
// ----------------------------------------------------------------------------
module tb_lca_path_sum_engine_top;
  import lps_pkg::*;

  localparam int NODES = MAX_NODES_DEF;
  localparam int LVL   = LEVELS_DEF;
  localparam int IN_W  = $bits(in_item_t);

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  lca_path_sum_engine_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // The clock runs at a 12 ns period.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Shadow copy of the lifting tables, kept in step with every accepted beat.
  logic [9:0]       depth_of   [NODES];
  logic [9:0]       lift_anc   [NODES][LVL];
  logic [SUM_W-1:0] lift_nsum  [NODES][LVL];
  logic [SUM_W-1:0] lift_esum  [NODES][LVL];
  logic [SUM_W-1:0] value_of   [NODES];
  bit               is_loaded  [NODES];
  int               loaded_list[$];
  int               last_loaded;

  out_item_t path_results_due[$];

  int fail_count;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_off_cycles;
  int loads_sent;
  int queries_sent;
  int results_seen;

  // Random filler for the whole payload.
  function automatic in_item_t rand_item();
    return in_item_t'(IN_W'({$urandom, $urandom, $urandom, $urandom}));
  endfunction

  // Applies one load to the shadow tables.
  function automatic void shadow_load(in_item_t it);
    int u;
    int p;
    int mid;
    u = int'(it.node);
    p = int'(it.parent_node);
    if (u == 0) return;
    depth_of[u] = (p == 0) ? 10'd0 : depth_of[p] + 10'd1;
    value_of[u] = {{(SUM_W-VAL_W){it.node_value[VAL_W-1]}}, it.node_value};
    lift_anc[u][0]  = p[9:0];
    lift_nsum[u][0] = value_of[u];
    lift_esum[u][0] = {{(SUM_W-VAL_W){it.edge_weight[VAL_W-1]}}, it.edge_weight};
    for (int k = 1; k < LVL; k++) begin
      mid = int'(lift_anc[u][k-1]);
      lift_anc[u][k]  = lift_anc[mid][k-1];
      lift_nsum[u][k] = lift_nsum[u][k-1] + lift_nsum[mid][k-1];
      lift_esum[u][k] = lift_esum[u][k-1] + lift_esum[mid][k-1];
    end
    if (!is_loaded[u]) loaded_list.push_back(u);
    is_loaded[u] = 1'b1;
    last_loaded  = u;
  endfunction

  // Works out the ancestor and both path sums for one query.
  function automatic out_item_t shadow_path_query(in_item_t it);
    out_item_t        res;
    int               u;
    int               v;
    int               t;
    logic [9:0]       diff;
    logic [SUM_W-1:0] ns;
    logic [SUM_W-1:0] es;
    u  = int'(it.node);
    v  = int'(it.other_node);
    ns = '0;
    es = '0;
    if (depth_of[u] < depth_of[v]) begin
      t = u; u = v; v = t;
    end
    diff = depth_of[u] - depth_of[v];
    for (int i = 0; i < LVL; i++) begin
      if (diff[i]) begin
        ns += lift_nsum[u][i];
        es += lift_esum[u][i];
        u  = int'(lift_anc[u][i]);
      end
    end
    if (u != v) begin
      for (int k = LVL - 1; k >= 0; k--) begin
        if (lift_anc[u][k] != lift_anc[v][k]) begin
          ns += lift_nsum[u][k] + lift_nsum[v][k];
          es += lift_esum[u][k] + lift_esum[v][k];
          t = int'(lift_anc[u][k]);
          v = int'(lift_anc[v][k]);
          u = t;
        end
      end
      ns += lift_nsum[u][0] + lift_nsum[v][0];
      es += lift_esum[u][0] + lift_esum[v][0];
      u  = int'(lift_anc[u][0]);
    end
    ns += value_of[u];
    res.common_ancestor = u[9:0];
    res.node_total      = ns;
    res.edge_total      = es;
    return res;
  endfunction

  // Offers one beat after a random gap and waits until the engine takes it.
  task automatic send_beat(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_data  <= rand_item();
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (it.mode == MODE_LOAD) begin
      shadow_load(it);
      loads_sent++;
    end else begin
      path_results_due.push_back(shadow_path_query(it));
      queries_sent++;
    end
  endtask

  // Lowers valid and waits until every expected result has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (path_results_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(4))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t make_load(int nd, int par);
    in_item_t it;
    it             = rand_item();
    it.mode        = MODE_LOAD;
    it.node        = nd[9:0];
    it.parent_node = par[9:0];
    it.edge_weight = pick_word();
    it.node_value  = pick_word();
    return it;
  endfunction

  function automatic in_item_t make_query(int a, int b);
    in_item_t it;
    it            = rand_item();
    it.mode       = MODE_QUERY;
    it.node       = a[9:0];
    it.other_node = b[9:0];
    return it;
  endfunction

  // Any loaded node, or now and then the empty sentinel.
  function automatic int pick_known();
    if ($urandom_range(40) == 0) return 0;
    return loaded_list[$urandom_range(loaded_list.size() - 1)];
  endfunction

  // Extremes of the fields, a node-zero load, root loads and sentinel queries.
  task automatic test_directed();
    send_beat(make_load(1, 0));
    send_beat(make_load(1023, 1));
    send_beat(make_load(512, 1023));
    send_beat(make_load(341, 512));
    send_beat(make_load(682, 1));
    send_beat(make_load(0, 1));
    send_beat(make_load(5, 0));
    send_beat(make_query(1023, 1023));
    send_beat(make_query(341, 682));
    send_beat(make_query(682, 341));
    send_beat(make_query(341, 1));
    send_beat(make_query(1, 512));
    send_beat(make_query(5, 341));
    send_beat(make_query(0, 341));
    send_beat(make_query(0, 0));
    send_beat(make_query(1023, 0));
    send_beat(make_load(1023, 5));
    send_beat(make_query(341, 1023));
    send_beat(make_query(512, 682));
    drain_results();
  endtask

  // A chain over five hundred deep, so every bit of the depth gap is walked.
  task automatic test_deep_chain();
    int prev;
    prev = 1;
    for (int n = 100; n < 700; n++) begin
      send_beat(make_load(n, prev));
      prev = n;
    end
    for (int q = 0; q < 30; q++)
      send_beat(make_query(pick_known(), pick_known()));
    drain_results();
  endtask

  // A mix of loads that mostly extend recent branches and queries on known nodes.
  task automatic test_random_mix(int count);
    int par;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 45) begin
        par = ($urandom_range(99) < 60) ? last_loaded : pick_known();
        send_beat(make_load($urandom_range(1023), par));
      end else begin
        send_beat(make_query(pick_known(), pick_known()));
      end
    end
    drain_results();
  endtask

  // The receiver stops for a long stretch while queries keep coming.
  task automatic test_output_backpressure();
    send_idle_pct   = 0;
    hold_off_cycles = 600;
    for (int i = 0; i < 30; i++)
      send_beat(make_query(pick_known(), pick_known()));
    drain_results();
  endtask

  // Receiver: random stall, or a counted hold-off when one is requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      out_stall       <= 1'b1;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Every accepted result beat is matched with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (path_results_due.size() == 0) begin
        $error("result beat with no query outstanding");
        fail_count++;
      end else begin
        want = path_results_due.pop_front();
        if (out_data.common_ancestor !== want.common_ancestor) begin
          $error("common_ancestor: expected %0d, got %0d",
                 want.common_ancestor, out_data.common_ancestor);
          fail_count++;
        end
        if (out_data.node_total !== want.node_total) begin
          $error("node_total: expected %0d, got %0d", want.node_total, out_data.node_total);
          fail_count++;
        end
        if (out_data.edge_total !== want.edge_total) begin
          $error("edge_total: expected %0d, got %0d", want.edge_total, out_data.edge_total);
          fail_count++;
        end
      end
    end
  end

  // Stop the run if the engine hangs.
  initial begin
    #25ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    fail_count      = 0;
    loads_sent      = 0;
    queries_sent    = 0;
    results_seen    = 0;
    hold_off_cycles = 0;
    last_loaded     = 0;
    send_idle_pct   = 29;
    recv_idle_pct   = 64;
    for (int n = 0; n < NODES; n++) begin
      depth_of[n]  = '0;
      value_of[n]  = '0;
      is_loaded[n] = 1'b0;
      for (int k = 0; k < LVL; k++) begin
        lift_anc[n][k]  = '0;
        lift_nsum[n][k] = '0;
        lift_esum[n][k] = '0;
      end
    end
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_deep_chain();
    test_random_mix(250);
    send_idle_pct = 64;
    recv_idle_pct = 29;
    test_random_mix(250);
    test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(200);

    $display("Covered %0d loads and %0d path queries, %0d results checked.",
             loads_sent, queries_sent, results_seen);
    $display("Chains over 500 deep, sentinel queries, extremes and long output hold-off.");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
